@@ rtl/edid_pkg.sv @@
// Shared types and constants for the EDID base block mode extractor.
// No dependencies; imported by every module of the block.
`default_nettype none

package edid_pkg;

  // Block layout
  localparam int BlockBytes = 128;
  localparam int PosW       = 7;
  localparam int EstOffset  = 35;
  localparam int StdOffset  = 38;
  localparam int StdBytes   = 16;
  localparam int StdW       = StdBytes * 8;

  // Field widths
  localparam int WidthW   = 12;
  localparam int HeightW  = 11;
  localparam int RefreshW = 7;
  localparam int StatusW  = 2;
  localparam int TotalW   = 5;

  // Done-item status codes
  localparam logic [StatusW-1:0] STATUS_OK       = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_SUM  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_BAD_HDR  = 2'd2;

  // Result kinds
  localparam logic KIND_MODE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // Header byte values
  localparam logic [7:0] HDR_EDGE = 8'h00;
  localparam logic [7:0] HDR_FILL = 8'hFF;

  // Unused standard slot marker
  localparam logic [7:0] STD_UNUSED = 8'h01;

  // Standard timing arithmetic
  localparam logic [8:0]  StdWidthBias = 9'd31;
  localparam logic [6:0]  RefreshBase  = 7'd60;
  localparam logic [13:0] RecipFifth   = 14'd13108;  // ceil(2^16 / 5)

  // Aspect codes in bits 7..6 of the second slot byte
  localparam logic [1:0] ASPECT_16_10 = 2'd0;
  localparam logic [1:0] ASPECT_4_3   = 2'd1;
  localparam logic [1:0] ASPECT_5_4   = 2'd2;
  localparam logic [1:0] ASPECT_16_9  = 2'd3;

  // One finished block handed from the front to the back
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [7:0]         est;
    logic [StdW-1:0]    std;   // byte at offset 38 in bits 7:0
  } job_t;

  typedef struct packed {
    logic [WidthW-1:0]   width;
    logic [HeightW-1:0]  height;
    logic [RefreshW-1:0] refresh;
  } mode_t;

  // Established timings, index 0 is bit 7
  function automatic mode_t est_mode(input logic [2:0] idx);
    mode_t m;
    case (idx)
      3'd0:    m = '{12'd720, 11'd400, 7'd70};
      3'd1:    m = '{12'd720, 11'd400, 7'd88};
      3'd2:    m = '{12'd640, 11'd480, 7'd60};
      3'd3:    m = '{12'd640, 11'd480, 7'd67};
      3'd4:    m = '{12'd640, 11'd480, 7'd72};
      3'd5:    m = '{12'd640, 11'd480, 7'd75};
      3'd6:    m = '{12'd800, 11'd600, 7'd56};
      default: m = '{12'd800, 11'd600, 7'd60};
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/edid_front.sv @@
// Front end: takes one byte per beat, keeps sum, header flag and timing bytes.
// Depends on edid_pkg; hands a job_t to the queue on the last byte of a block.
`default_nettype none

module edid_front
  import edid_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  output logic            push,
  output job_t            job
);

  logic [PosW-1:0] pos_r;
  logic [7:0]      sum_r;
  logic            hdr_ok_r;
  logic [7:0]      est_r;
  logic [StdW-1:0] std_r;

  logic [7:0]      sum_nxt;
  logic            hdr_ok_nxt;
  logic [7:0]      hdr_want;
  logic            last_byte;
  logic            in_std;

  // Per-byte bookkeeping
  always_comb begin
    sum_nxt    = sum_r + data_byte;
    hdr_want   = (pos_r == PosW'(0) || pos_r == PosW'(7)) ? HDR_EDGE : HDR_FILL;
    hdr_ok_nxt = hdr_ok_r;
    if (pos_r < PosW'(8) && data_byte != hdr_want) begin
      hdr_ok_nxt = 1'b0;
    end
    last_byte = (pos_r == PosW'(BlockBytes - 1));
    in_std    = (pos_r >= PosW'(StdOffset)) && (pos_r < PosW'(StdOffset + StdBytes));
  end

  // Job for the back end, built from the state after this byte
  always_comb begin
    push       = accept && last_byte;
    job.est    = est_r;
    job.std    = std_r;
    if (sum_nxt != 8'd0) begin
      job.status = STATUS_BAD_SUM;
    end else if (!hdr_ok_nxt) begin
      job.status = STATUS_BAD_HDR;
    end else begin
      job.status = STATUS_OK;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      sum_r    <= '0;
      hdr_ok_r <= 1'b1;
      est_r    <= '0;
    end else if (accept) begin
      pos_r <= pos_r + PosW'(1);
      if (last_byte) begin
        sum_r    <= '0;
        hdr_ok_r <= 1'b1;
        est_r    <= '0;
      end else begin
        sum_r    <= sum_nxt;
        hdr_ok_r <= hdr_ok_nxt;
        if (pos_r == PosW'(EstOffset)) begin
          est_r <= data_byte;
        end
      end
    end
  end

  // Standard timing bytes shift in from the top; offset 38 ends at bits 7:0
  always_ff @(posedge clk) begin
    if (accept && in_std) begin
      std_r <= {data_byte, std_r[StdW-1:8]};
    end
  end

endmodule

`default_nettype wire

@@ rtl/edid_fifo.sv @@
// Two-entry job queue between the front and back ends.
// Depends on edid_pkg for job_t.
`default_nettype none

module edid_fifo
  import edid_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      head,
  output logic      empty,
  output logic      full
);

  job_t       mem_r [2];
  logic       wr_r;
  logic       rd_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rd_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= ~wr_r;
      if (pop)  rd_r <= ~rd_r;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop)
    else $error("job popped from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("queue count out of range");

endmodule

`default_nettype wire

@@ rtl/edid_back.sv @@
// Back end: walks established bits, then standard slots, then the done item; a rejected block gets only the done item.
// Depends on edid_pkg; reads jobs from edid_fifo and drives the result beats.
`default_nettype none

module edid_back
  import edid_pkg::*;
#(
  parameter int STANDARD_SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire job_t              head,
  input  wire logic              empty,
  output logic                   pop,
  output logic                   out_valid,
  output logic                   out_kind,
  output logic [WidthW-1:0]      out_width,
  output logic [HeightW-1:0]     out_height,
  output logic [RefreshW-1:0]    out_refresh,
  output logic                   out_preferred,
  output logic [StatusW-1:0]     out_status,
  output logic [TotalW-1:0]      out_mode_total,
  output logic                   out_last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EST  = 2'd1;
  localparam logic [1:0] ST_STD  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] LastSlot = 3'(STANDARD_SLOTS - 1);

  logic [1:0]         state_r, state_nxt;
  logic [7:0]         est_r;
  logic [StdW-1:0]    std_r;
  logic [StatusW-1:0] status_r;
  logic [TotalW-1:0]  count_r;
  logic [2:0]         idx_r;      // established bit or slot number

  logic               emit;
  mode_t              est_m;
  logic [7:0]         slot_h;
  logic [7:0]         slot_v;
  logic [8:0]         s;
  logic [22:0]        fifth_prod;
  mode_t              std_m;

  logic                kind_nxt;
  logic                preferred_nxt;
  logic [StatusW-1:0]  status_nxt;
  logic [TotalW-1:0]   total_nxt;
  logic                last_nxt;
  logic [WidthW-1:0]   width_nxt;
  logic [HeightW-1:0]  height_nxt;
  logic [RefreshW-1:0] refresh_nxt;

  // Standard slot decode: width = 8*(h+31), height by aspect
  always_comb begin
    slot_h     = std_r[7:0];
    slot_v     = std_r[15:8];
    s          = {1'b0, slot_h} + StdWidthBias;
    fifth_prod = 23'(s) * 23'(RecipFifth);
    std_m.width   = {s, 3'b000};
    std_m.refresh = {1'b0, slot_v[5:0]} + RefreshBase;
    case (slot_v[7:6])
      ASPECT_16_10: std_m.height = 11'(s) * 11'd5;
      ASPECT_4_3:   std_m.height = 11'(s) * 11'd6;
      ASPECT_5_4:   std_m.height = fifth_prod[21:11];
      default:      std_m.height = HeightW'((12'(s) * 12'd9) >> 1);
    endcase
    est_m = est_mode(idx_r);
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = (head.status == STATUS_OK) ? ST_EST : ST_DONE;
        end
      end
      ST_EST: begin
        emit = est_r[7];
        if (idx_r == 3'd7) state_nxt = ST_STD;
      end
      ST_STD: begin
        if (slot_h == 8'd0) begin
          state_nxt = ST_DONE;
        end else begin
          emit = !(slot_h == STD_UNUSED && slot_v == STD_UNUSED);
          if (idx_r == LastSlot) state_nxt = ST_DONE;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          count_r <= '0;
          idx_r   <= '0;
        end
        ST_EST: begin
          idx_r <= idx_r + 3'd1;   // wraps to slot 0 on the way to ST_STD
          if (emit) count_r <= count_r + TotalW'(1);
        end
        ST_STD: begin
          idx_r <= idx_r + 3'd1;
          if (emit) count_r <= count_r + TotalW'(1);
        end
        default: idx_r <= idx_r;
      endcase
    end
  end

  // Job payload: established bits shift out MSB first, slots 16 bits at a time
  always_ff @(posedge clk) begin
    if (pop) begin
      est_r    <= head.est;
      std_r    <= head.std;
      status_r <= head.status;
    end else if (state_r == ST_EST) begin
      est_r <= {est_r[6:0], 1'b0};
    end else if (state_r == ST_STD) begin
      std_r <= {16'd0, std_r[StdW-1:16]};
    end
  end

  // Result register: at most one beat per cycle, no back-pressure
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit || (state_r == ST_DONE);
    end
  end

  // Result fields for the current state
  always_comb begin
    kind_nxt      = KIND_MODE;
    preferred_nxt = 1'b0;
    status_nxt    = STATUS_OK;
    total_nxt     = '0;
    last_nxt      = 1'b0;
    width_nxt     = '0;
    height_nxt    = '0;
    refresh_nxt   = '0;
    if (state_r == ST_EST) begin
      width_nxt   = est_m.width;
      height_nxt  = est_m.height;
      refresh_nxt = est_m.refresh;
    end else if (state_r == ST_STD) begin
      width_nxt     = std_m.width;
      height_nxt    = std_m.height;
      refresh_nxt   = std_m.refresh;
      preferred_nxt = (idx_r == 3'd0);
    end else if (state_r == ST_DONE) begin
      kind_nxt   = KIND_DONE;
      status_nxt = status_r;
      total_nxt  = count_r;
      last_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_kind       <= kind_nxt;
    out_preferred  <= preferred_nxt;
    out_status     <= status_nxt;
    out_mode_total <= total_nxt;
    out_last       <= last_nxt;
    out_width      <= width_nxt;
    out_height     <= height_nxt;
    out_refresh    <= refresh_nxt;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_mode_total <= TotalW'(16))
    else $error("mode total exceeds sixteen");
  a_bad_no_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && out_status != STATUS_OK |-> out_mode_total == '0)
    else $error("modes emitted for a rejected block");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_EST || state_r == ST_DONE)
    else $error("job loaded outside idle");
  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == out_kind))
    else $error("last flag and kind disagree");

endmodule

`default_nettype wire

@@ rtl/edid_mode_extractor_core.sv @@
// EDID base block mode extractor: takes the 128 bytes of a base block one
// beat per cycle (start high, busy low) and counts the offset itself. After
// byte 127 the block is queued; a sequencer then puts out one result beat per
// cycle at most, strobed by out_valid for a single cycle, since the receiver
// cannot stall. For a block with good checksum and header it gives one mode
// per set established bit (bit 7 first), then one per standard slot not
// marked unused, among the first STANDARD_SLOTS and up to the first slot
// whose first byte is zero; every block ends in a done beat with status and
// mode total. The two-entry queue raises busy only when two finished blocks
// are still waiting, so at one byte per cycle input is never held off.
// Depends on edid_pkg, edid_front, edid_fifo and edid_back.
`default_nettype none

module edid_mode_extractor_core
  import edid_pkg::*;
#(
  parameter int STANDARD_SLOTS = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [7:0]          in_data_byte,
  output logic                     out_valid,
  output logic                     out_kind,
  output logic [WidthW-1:0]        out_width,
  output logic [HeightW-1:0]       out_height,
  output logic [RefreshW-1:0]      out_refresh,
  output logic                     out_preferred,
  output logic [StatusW-1:0]       out_status,
  output logic [TotalW-1:0]        out_mode_total,
  output logic                     out_last
);

  logic accept;
  logic push;
  job_t push_job;
  job_t head;
  logic empty;
  logic full;
  logic pop;

  assign busy   = full;
  assign accept = start && !busy;

  // Byte accumulation
  edid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .data_byte (in_data_byte),
    .push      (push),
    .job       (push_job)
  );

  // Finished blocks waiting for the sequencer
  edid_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  // Mode sequencer
  edid_back #(
    .STANDARD_SLOTS (STANDARD_SLOTS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .empty          (empty),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_refresh    (out_refresh),
    .out_preferred  (out_preferred),
    .out_status     (out_status),
    .out_mode_total (out_mode_total),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire
